[src/bscml_pkg.sv]
package bscml_pkg;

    localparam int PIX_W   = 8;
    localparam int LW_W    = 11;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_RED_EN   = 3'd0;
    localparam logic [2:0] REG_GREEN_EN = 3'd1;
    localparam logic [2:0] REG_BLUE_EN  = 3'd2;
    localparam logic [2:0] REG_MONO_EN  = 3'd3;
    localparam logic [2:0] REG_SHRINK   = 3'd4;
    localparam logic [2:0] REG_LINE_W   = 3'd5;

    // Q0.8 luma weights, sum to 256
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef struct packed {
        logic             red_en;
        logic             green_en;
        logic             blue_en;
        logic             mono_en;
        logic [1:0]       shrink_level;
        logic [LW_W-1:0]  line_width;
    } t_cfg;

    typedef struct packed {
        logic first_row;   // start the block sum afresh, no read needed
        logic wr;          // store the block sum
        logic emit;        // block complete, produce a word
        logic row_last;    // last block of the shrunk row
    } t_blk_flags;

    function automatic logic [1:0] f_eff_shrink(input logic [1:0] lvl, input int max_lvl);
        logic [1:0] res;
        res = (int'(lvl) > max_lvl) ? 2'(max_lvl) : lvl;
        return res;
    endfunction

endpackage

[src/bscml_ram.sv]
module bscml_ram import bscml_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/bscml_front.sv]
module bscml_front import bscml_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_SHRINK = 3,
    parameter int HW         = PIX_W + MAX_SHRINK,
    parameter int AW         = $clog2(MAX_WIDTH / 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    input  logic [PIX_W-1:0]       i_red_in,
    input  logic [PIX_W-1:0]       i_green_in,
    input  logic [PIX_W-1:0]       i_blue_in,
    input  logic                   i_frame_start,
    input  logic                   i_q_full,
    output logic                   o_stall,
    output logic                   o_push,
    output logic [2:0][HW-1:0]     o_hsum,
    output logic [AW-1:0]          o_addr,
    output t_blk_flags             o_flags
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = ((CW > LW_W) ? CW : LW_W) + 1;

    logic [CW-1:0]         r_col;
    logic [2:0]            r_row;
    logic [2:0][HW-1:0]    r_hsum;

    logic [CW-1:0]         n_col;
    logic [2:0]            n_row;
    logic [2:0][HW-1:0]    n_hsum;

    logic                  accept;
    logic [1:0]            k;
    logic [2:0]            kmask;
    logic [LW_W-1:0]       width;
    logic [CW-1:0]         c;
    logic [2:0]            row;
    logic [2:0][HW-1:0]    hs;
    logic [2:0][HW-1:0]    hs_sum;
    logic [2:0][PIX_W-1:0] pix;
    logic [XW-1:0]         cx;
    logic [XW-1:0]         wx;
    logic [XW-1:0]         bx;
    logic [XW-1:0]         blocks;
    logic                  in_range;
    logic                  seg_end;
    logic                  last_row;
    logic                  line_end;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    always_comb begin
        pix[CH_R] = i_red_in;
        pix[CH_G] = i_green_in;
        pix[CH_B] = i_blue_in;

        k     = f_eff_shrink(i_cfg.shrink_level, MAX_SHRINK);
        kmask = 3'((4'd1 << k) - 4'd1);
        if (i_cfg.line_width == '0) begin
            width = LW_W'(1);
        end else if (int'(i_cfg.line_width) > MAX_WIDTH) begin
            width = LW_W'(MAX_WIDTH);
        end else begin
            width = i_cfg.line_width;
        end

        c   = i_frame_start ? '0 : r_col;
        row = i_frame_start ? '0 : r_row;
        hs  = i_frame_start ? '0 : r_hsum;

        cx       = XW'(c);
        wx       = XW'(width);
        in_range = cx < (wx & ~XW'(kmask));
        bx       = cx >> k;
        blocks   = wx >> k;
        seg_end  = (c[2:0] & kmask) == kmask;
        last_row = row >= kmask;
        line_end = (cx + XW'(1)) >= wx;

        for (int ch = 0; ch < 3; ch++) begin
            hs_sum[ch] = hs[ch] + HW'(pix[ch]);
            o_hsum[ch] = (k == 2'd0) ? HW'(pix[ch]) : hs_sum[ch];
        end

        o_push             = accept && in_range && ((k == 2'd0) || seg_end);
        o_addr             = AW'(bx);
        o_flags.first_row  = (k == 2'd0) || (row == 3'd0);
        o_flags.wr         = (k != 2'd0);
        o_flags.emit       = (k == 2'd0) || last_row;
        o_flags.row_last   = (bx == blocks - XW'(1));

        if (line_end) begin
            n_hsum = '0;
        end else if (in_range && (k != 2'd0)) begin
            n_hsum = seg_end ? '0 : hs_sum;
        end else begin
            n_hsum = hs;
        end
        n_col = line_end ? '0 : CW'(cx + XW'(1));
        if (line_end) begin
            n_row = last_row ? 3'd0 : row + 3'd1;
        end else begin
            n_row = row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_hsum <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_hsum <= n_hsum;
        end
    end

endmodule

[src/bscml_queue.sv]
module bscml_queue import bscml_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [NW-1:0]    r_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count past depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

[src/bscml_back.sv]
module bscml_back import bscml_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_SHRINK = 3,
    parameter int HW         = PIX_W + MAX_SHRINK,
    parameter int AW         = $clog2(MAX_WIDTH / 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_valid,
    input  logic [2:0][HW-1:0]     i_hsum,
    input  logic [AW-1:0]          i_addr,
    input  t_blk_flags             i_flags,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIX_W-1:0]       o_red_out,
    output logic [PIX_W-1:0]       o_green_out,
    output logic [PIX_W-1:0]       o_blue_out,
    output logic                   o_row_end
);

    localparam int SW    = PIX_W + 2 * MAX_SHRINK;
    localparam int DEPTH = MAX_WIDTH / 2;

    // stage 1: block sum update
    logic                    r_s1_valid;
    t_blk_flags              r_s1_flags;
    logic [2:0][HW-1:0]      r_s1_hsum;
    logic [AW-1:0]           r_s1_addr;
    logic                    r_fwd;
    logic [2:0][SW-1:0]      r_fwd_data;
    // stage 2: averaged pixel
    logic                    r_s2_valid;
    logic                    r_s2_last;
    logic [2:0][PIX_W-1:0]   r_s2_avg;
    // output word
    logic                    r_out_valid;
    logic                    r_out_last;
    logic [2:0][PIX_W-1:0]   r_out_pix;

    logic                    adv;
    logic                    wen;
    logic [2:0][SW-1:0]      rdata;
    logic [2:0][SW-1:0]      base;
    logic [2:0][SW-1:0]      sum;
    logic [2:0][PIX_W-1:0]   avg;
    logic [2:0][PIX_W-1:0]   masked;
    logic [2:0][PIX_W-1:0]   n_pix;
    logic [2:0]              ch_en;
    logic [1:0]              k;
    logic [15:0]             luma_sum;

    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && i_q_valid;
    assign wen   = adv && r_s1_valid && r_s1_flags.wr;

    bscml_ram #(
        .WIDTH (3 * SW),
        .DEPTH (DEPTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (wen),
        .i_waddr (r_s1_addr),
        .i_wdata (sum),
        .i_re    (o_pop),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        k = f_eff_shrink(i_cfg.shrink_level, MAX_SHRINK);
        for (int ch = 0; ch < 3; ch++) begin
            // a write landing on the address read in the same cycle is taken from r_fwd_data
            base[ch] = r_fwd ? r_fwd_data[ch] : rdata[ch];
            sum[ch]  = (r_s1_flags.first_row ? '0 : base[ch]) + SW'(r_s1_hsum[ch]);
            avg[ch]  = PIX_W'(sum[ch] >> {k, 1'b0});
        end

        ch_en[CH_R] = i_cfg.red_en;
        ch_en[CH_G] = i_cfg.green_en;
        ch_en[CH_B] = i_cfg.blue_en;
        for (int ch = 0; ch < 3; ch++) begin
            masked[ch] = ch_en[ch] ? r_s2_avg[ch] : '0;
        end
        luma_sum = 16'(LUMA_R) * 16'(masked[CH_R])
                 + 16'(LUMA_G) * 16'(masked[CH_G])
                 + 16'(LUMA_B) * 16'(masked[CH_B]);
        for (int ch = 0; ch < 3; ch++) begin
            n_pix[ch] = i_cfg.mono_en ? luma_sum[15:8] : masked[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_q_valid;
            r_s2_valid  <= r_s1_valid && r_s1_flags.emit;
            r_out_valid <= r_s2_valid;
            r_fwd       <= wen && o_pop && (i_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_flags <= i_flags;
            r_s1_hsum  <= i_hsum;
            r_s1_addr  <= i_addr;
            r_fwd_data <= sum;
            r_s2_avg   <= avg;
            r_s2_last  <= r_s1_flags.row_last;
            r_out_pix  <= n_pix;
            r_out_last <= r_s2_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_out_pix[CH_R];
    assign o_green_out = r_out_pix[CH_G];
    assign o_blue_out  = r_out_pix[CH_B];
    assign o_row_end   = r_out_last;

`ifndef SYNTHESIS
    a_fwd_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && wen && o_pop && (i_addr == r_s1_addr)) |=> r_fwd)
        else $error("same-address write not forwarded");
    a_s2_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_s1_valid) |=> !r_s2_valid)
        else $error("averaged word without a block sum");
    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_s2_valid) |=> !r_out_valid)
        else $error("output word without an averaged word");
`endif

endmodule

[src/box_shrink_channel_mask_luma.sv]
// A pixel that completes a block shows its word after passing the queue, block sum update, average, mask and
// luma registers in that order, and it waits longer while the output is stalled.
// Throughput: one pixel per cycle while o_stall is low; the 4-word queue lets the front run on while the
// output side stalls, and o_stall rises once that queue is full.
// Reset (synchronous, i_rst_n low): counters, sums, queue and config return to defaults;
// the block sum memory is not cleared, the first row of each block row overwrites it.
module box_shrink_channel_mask_luma import bscml_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_SHRINK = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [PIX_W-1:0]    i_red_in,
    input  logic [PIX_W-1:0]    i_green_in,
    input  logic [PIX_W-1:0]    i_blue_in,
    input  logic                i_frame_start,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [PIX_W-1:0]    o_red_out,
    output logic [PIX_W-1:0]    o_green_out,
    output logic [PIX_W-1:0]    o_blue_out,
    output logic                o_row_end
);

    localparam int HW          = PIX_W + MAX_SHRINK;
    localparam int AW          = $clog2(MAX_WIDTH / 2);
    localparam int EW          = $bits(t_blk_flags) + AW + 3 * HW;
    localparam int QUEUE_DEPTH = 4;

    t_cfg                r_cfg;
    logic                cfg_wr;

    logic                q_full;
    logic                push;
    logic [2:0][HW-1:0]  f_hsum;
    logic [AW-1:0]       f_addr;
    t_blk_flags          f_flags;
    logic                q_valid;
    logic                pop;
    logic [EW-1:0]       q_out;
    logic [2:0][HW-1:0]  b_hsum;
    logic [AW-1:0]       b_addr;
    t_blk_flags          b_flags;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_en       <= 1'b1;
            r_cfg.green_en     <= 1'b1;
            r_cfg.blue_en      <= 1'b1;
            r_cfg.mono_en      <= 1'b0;
            r_cfg.shrink_level <= 2'd0;
            r_cfg.line_width   <= LW_W'(1024);
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_RED_EN:   r_cfg.red_en       <= pwdata[0];
                REG_GREEN_EN: r_cfg.green_en     <= pwdata[0];
                REG_BLUE_EN:  r_cfg.blue_en      <= pwdata[0];
                REG_MONO_EN:  r_cfg.mono_en      <= pwdata[0];
                REG_SHRINK:   r_cfg.shrink_level <= pwdata[1:0];
                REG_LINE_W:   r_cfg.line_width   <= pwdata[LW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_RED_EN:   prdata = PDATA_W'(r_cfg.red_en);
            REG_GREEN_EN: prdata = PDATA_W'(r_cfg.green_en);
            REG_BLUE_EN:  prdata = PDATA_W'(r_cfg.blue_en);
            REG_MONO_EN:  prdata = PDATA_W'(r_cfg.mono_en);
            REG_SHRINK:   prdata = PDATA_W'(r_cfg.shrink_level);
            REG_LINE_W:   prdata = PDATA_W'(r_cfg.line_width);
            default:      prdata = '0;
        endcase
    end

    bscml_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SHRINK (MAX_SHRINK),
        .HW         (HW),
        .AW         (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_stall       (o_stall),
        .o_push        (push),
        .o_hsum        (f_hsum),
        .o_addr        (f_addr),
        .o_flags       (f_flags)
    );

    bscml_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_flags, f_addr, f_hsum}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {b_flags, b_addr, b_hsum} = q_out;

    bscml_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SHRINK (MAX_SHRINK),
        .HW         (HW),
        .AW         (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_hsum      (b_hsum),
        .i_addr      (b_addr),
        .i_flags     (b_flags),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_row_end   (o_row_end)
    );

endmodule

[tb/box_shrink_channel_mask_luma_test.sv]
module box_shrink_channel_mask_luma_test;
    import bscml_pkg::*;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_SHRINK  = 3;
    localparam int BLOCK_SLOTS = MAX_WIDTH / 2;
    localparam int LUMA_WR     = 77;
    localparam int LUMA_WG     = 150;
    localparam int LUMA_WB     = 29;
    localparam int SETTLE      = 8;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_PIX    = 64;
    localparam int RANDOM_PIX  = 550;
    localparam int PHASE_CAP   = 400;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
    } t_rgb_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [PIX_W-1:0]   i_red_in = '0;
    logic [PIX_W-1:0]   i_green_in = '0;
    logic [PIX_W-1:0]   i_blue_in = '0;
    logic               i_frame_start = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [PIX_W-1:0]   o_red_out;
    logic [PIX_W-1:0]   o_green_out;
    logic [PIX_W-1:0]   o_blue_out;
    logic               o_row_end;

    box_shrink_channel_mask_luma #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SHRINK (MAX_SHRINK)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_row_end     (o_row_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's registers and position state
    t_cfg        shadow_cfg;
    int unsigned col_pos;
    int unsigned blk_row;
    int unsigned row_acc [3];
    int unsigned block_acc [BLOCK_SLOTS][3];

    t_pixel      pending_pixels[$];
    t_rgb_word   expected_words[$];
    t_pixel      cur_pixel;
    int          errors = 0;
    bit          src_gappy = 1'b1;
    bit          sink_gappy = 1'b1;
    int          src_gap = 0;
    int          sink_run = 0;
    bit          sink_hold = 1'b0;
    int          hold_asked = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [PIX_W-1:0] rand_chan();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic t_rgb_word mask_and_luma(input int unsigned r, input int unsigned g,
                                                input int unsigned b, input bit last);
        t_rgb_word   w;
        int unsigned y;
        if (!shadow_cfg.red_en)
            r = 0;
        if (!shadow_cfg.green_en)
            g = 0;
        if (!shadow_cfg.blue_en)
            b = 0;
        if (shadow_cfg.mono_en) begin
            y = (LUMA_WR * r + LUMA_WG * g + LUMA_WB * b) >> 8;
            r = y;
            g = y;
            b = y;
        end
        w.red     = r[PIX_W-1:0];
        w.green   = g[PIX_W-1:0];
        w.blue    = b[PIX_W-1:0];
        w.row_end = last;
        return w;
    endfunction

    // advances the shadow state by one pixel; returns 1 when a word comes out
    function automatic bit shrink_pixel(input t_pixel p, output t_rgb_word w);
        int unsigned pix [3];
        int unsigned k, side, width, blocks, c, b;
        int          i;
        bit          last_row, row_last, produced;
        pix[0]   = p.red;
        pix[1]   = p.green;
        pix[2]   = p.blue;
        produced = 1'b0;
        w        = '0;
        if (p.frame_start) begin
            col_pos = 0;
            blk_row = 0;
            for (i = 0; i < 3; i++)
                row_acc[i] = 0;
        end
        k = shadow_cfg.shrink_level;
        if (k > MAX_SHRINK)
            k = MAX_SHRINK;
        side  = 1 << k;
        width = shadow_cfg.line_width;
        if (width < 1)
            width = 1;
        if (width > MAX_WIDTH)
            width = MAX_WIDTH;
        blocks   = width >> k;
        c        = col_pos;
        last_row = (blk_row >= side - 1);
        if (c < (blocks << k)) begin
            b        = c >> k;
            row_last = (b == blocks - 1);
            if (k == 0) begin
                w        = mask_and_luma(pix[0], pix[1], pix[2], row_last);
                produced = 1'b1;
            end else begin
                for (i = 0; i < 3; i++)
                    row_acc[i] += pix[i];
                if ((c & (side - 1)) == side - 1 && b < BLOCK_SLOTS) begin
                    for (i = 0; i < 3; i++) begin
                        if (blk_row == 0)
                            block_acc[b][i] = row_acc[i];
                        else
                            block_acc[b][i] += row_acc[i];
                        row_acc[i] = 0;
                    end
                    if (last_row) begin
                        w = mask_and_luma(block_acc[b][0] >> (2 * k),
                                          block_acc[b][1] >> (2 * k),
                                          block_acc[b][2] >> (2 * k), row_last);
                        produced = 1'b1;
                    end
                end
            end
        end
        if (c + 1 >= width) begin
            col_pos = 0;
            for (i = 0; i < 3; i++)
                row_acc[i] = 0;
            blk_row = last_row ? 0 : ((blk_row + 1) & 7);
        end else begin
            col_pos = c + 1;
        end
        return produced;
    endfunction

    function automatic void add_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                      input logic [PIX_W-1:0] b, input logic fs);
        t_pixel p;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        p.frame_start = fs;
        pending_pixels.push_back(p);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // unused upper data bits carry noise
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [PDATA_W-1:0] data;
        data = $urandom();
        case (idx)
            REG_RED_EN: begin
                data[0] = value[0];
                shadow_cfg.red_en = value[0];
            end
            REG_GREEN_EN: begin
                data[0] = value[0];
                shadow_cfg.green_en = value[0];
            end
            REG_BLUE_EN: begin
                data[0] = value[0];
                shadow_cfg.blue_en = value[0];
            end
            REG_MONO_EN: begin
                data[0] = value[0];
                shadow_cfg.mono_en = value[0];
            end
            REG_SHRINK: begin
                data[1:0] = value[1:0];
                shadow_cfg.shrink_level = value[1:0];
            end
            REG_LINE_W: begin
                data[LW_W-1:0] = value[LW_W-1:0];
                shadow_cfg.line_width = value[LW_W-1:0];
            end
            default: ;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(input bit r, input bit g, input bit b, input bit mono,
                             input logic [1:0] k, input logic [LW_W-1:0] w);
        write_reg(REG_RED_EN, 32'(r));
        write_reg(REG_GREEN_EN, 32'(g));
        write_reg(REG_BLUE_EN, 32'(b));
        write_reg(REG_MONO_EN, 32'(mono));
        write_reg(REG_SHRINK, 32'(k));
        write_reg(REG_LINE_W, 32'(w));
    endtask

    // sender quiet and every word back, then a settling wait for pixels still in flight
    task automatic drain();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_valid || expected_words.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : pixel_driver
        t_pixel    nxt;
        t_rgb_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                if (shrink_pixel(cur_pixel, w))
                    expected_words.push_back(w);
            end
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    nxt           = pending_pixels.pop_front();
                    cur_pixel     = nxt;
                    i_red_in      <= nxt.red;
                    i_green_in    <= nxt.green;
                    i_blue_in     <= nxt.blue;
                    i_frame_start <= nxt.frame_start;
                    i_valid       <= 1'b1;
                    src_gap       = src_gappy ? idle_len() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : word_sink
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!sink_gappy) begin
            i_stall <= 1'b0;
        end else begin
            if (sink_run == 0) begin
                sink_hold = ($urandom_range(0, 2) == 0);
                sink_run  = sink_hold ? idle_len() + 1 : $urandom_range(1, 12);
            end
            sink_run--;
            i_stall <= sink_hold;
        end
    end

    always @(posedge i_clk) begin : word_monitor
        t_rgb_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual r %0d g %0d b %0d end %0b",
                         $time, o_red_out, o_green_out, o_blue_out, o_row_end);
                errors++;
            end else begin
                want = expected_words.pop_front();
                check_field("red_out", want.red, o_red_out);
                check_field("green_out", want.green, o_green_out);
                check_field("blue_out", want.blue, o_blue_out);
                check_field("row_end", want.row_end, o_row_end);
            end
        end
    end

    initial begin : stimulus
        int          n, i, count, eff_w, fs_rate;
        logic [1:0]  k;
        logic [10:0] wr;
        bit          fs_first;
        shadow_cfg.red_en       = 1'b1;
        shadow_cfg.green_en     = 1'b1;
        shadow_cfg.blue_en      = 1'b1;
        shadow_cfg.mono_en      = 1'b0;
        shadow_cfg.shrink_level = 2'd0;
        shadow_cfg.line_width   = 11'd1024;
        col_pos = 0;
        blk_row = 0;
        for (i = 0; i < 3; i++)
            row_acc[i] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: every pixel is a word of its own
        add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        add_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
        drain();

        // zero width reads as one, narrower than a 2x2 block: nothing out
        write_reg(REG_SHRINK, 32'd1);
        write_reg(REG_LINE_W, 32'd0);
        add_pixel(8'hFF, 8'h00, 8'h80, 1'b1);
        add_pixel(8'h01, 8'hFE, 8'h7F, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        drain();

        // 5-wide lines in 2x2 blocks, red masked, luma on; trailing column dropped
        write_reg(REG_LINE_W, 32'd5);
        write_reg(REG_RED_EN, 32'd0);
        write_reg(REG_MONO_EN, 32'd1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pixel(8'h10, 8'h20, 8'h30, 1'b0);
        add_pixel(8'h01, 8'h03, 8'h07, 1'b0);
        add_pixel(8'h99, 8'h99, 8'h99, 1'b0);
        add_pixel(8'hFF, 8'hFE, 8'hFD, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
        drain();

        // drop to no shrink mid-frame: column beyond the new line end and the
        // row counter both wrap
        write_all(1'b1, 1'b0, 1'b0, 1'b0, 2'd0, 11'd2);
        for (i = 0; i < 4; i++)
            add_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
        drain();

        // long output hold while pixels keep coming, so the input side backs up
        write_all(1'b1, 1'b1, 1'b1, 1'b0, 2'd0, 11'd16);
        src_gappy = 1'b0;
        hold_asked++;
        for (i = 0; i < HOLD_PIX; i++)
            add_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
        drain();
        src_gappy = 1'b1;

        // widest line (over-range width clamps), no shrink: reaches the last column
        write_all(1'b1, 1'b1, 1'b0, 1'b0, 2'd0, 11'd2047);
        for (i = 0; i < MAX_WIDTH + 3; i++)
            add_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
        drain();

        write_all(1'b0, 1'b1, 1'b1, 1'b1, 2'd3, 11'd1024);
        for (i = 0; i < 20; i++)
            add_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
        drain();

        n = 0;
        while (n < RANDOM_PIX) begin
            k = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: wr = 11'($urandom_range(0, 2));
                1: wr = 11'((8 << $urandom_range(0, 2)) + $urandom_range(0, 2) - 1);
                2: wr = (k == 0) ? 11'($urandom_range(1025, 2047)) : 11'($urandom_range(1, 40));
                default: wr = 11'($urandom_range(1, 40));
            endcase
            eff_w = (wr == 0) ? 1 : ((wr > MAX_WIDTH) ? MAX_WIDTH : wr);
            count = $urandom_range(1, 3) * (1 << k) * eff_w + $urandom_range(0, eff_w);
            if (count > PHASE_CAP)
                count = $urandom_range(PHASE_CAP / 2, PHASE_CAP);
            // only the no-shrink path may carry on without a frame start
            fs_first = !(k == 0 && $urandom_range(0, 3) == 0);
            // some phases are mostly broken frames
            fs_rate  = ($urandom_range(0, 4) == 0) ? 4 : 60;
            write_all($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                      $urandom_range(0, 3) != 0, $urandom_range(0, 2) == 0, k, wr);
            src_gappy  = ($urandom_range(0, 3) != 0);
            sink_gappy = ($urandom_range(0, 3) != 0);
            for (i = 0; i < count; i++)
                add_pixel(rand_chan(), rand_chan(), rand_chan(),
                          (i == 0) ? fs_first : ($urandom_range(0, fs_rate - 1) == 0));
            n += count;
            drain();
        end

        if (errors == 0)
            $display("box_shrink_channel_mask_luma verification clean");
        else
            $display("box_shrink_channel_mask_luma verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("box_shrink_channel_mask_luma verification failed");
        $finish;
    end

endmodule
